@@ rtl/core/backward_cluster_tracker_macros.svh @@
// Assertion macros shared by the tracker RTL.
`ifndef BACKWARD_CLUSTER_TRACKER_MACROS_SVH
`define BACKWARD_CLUSTER_TRACKER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BCT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tracker check failed");

// Next-cycle implication, held off during reset.
`define BCT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tracker check failed");

`endif

@@ rtl/core/bct_pkg.sv @@
// Shared types and widths for the backward cluster tracker.
package bct_pkg;
    localparam int PID_W  = 6;
    localparam int CARD_W = 13;
    localparam int REC_W  = 7;
    localparam int WIDE_W = 11;

    // Request type codes
    localparam logic REQ_COLLIDE = 1'b0;
    localparam logic REQ_REPORT  = 1'b1;

    // Broadcast command to every row cell.
    typedef struct packed {
        logic             upd;
        logic             clr_diag;
        logic [PID_W-1:0] p1;
        logic [PID_W-1:0] p2;
        logic             rb;
    } t_cmd;

    // Running statistics handed down the chain.
    typedef struct packed {
        logic [CARD_W-1:0] card;
        logic [REC_W-1:0]  rint;
        logic [REC_W-1:0]  rext;
    } t_link;
endpackage

@@ rtl/core/backward_cluster_tracker.sv @@
// Top level of the backward cluster tracker: row cell chain and report control.
// A collision transaction updates every row cell at once, so collisions stream
// back to back while no report is in progress. A report transaction holds the
// input while the union of later rows and the running sums ripple one cell per
// cycle down the chain until the totals reach cell 0, and longer while an
// earlier result is still stalled in the output register. The result then
// waits in an output register; collisions are taken meanwhile.
// Per-row recollision flags stand in for the member counts, which only matter
// through whether one ever exceeded one.
`include "backward_cluster_tracker_macros.svh"
module backward_cluster_tracker #(
    parameter int NUM_PARTICLES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [bct_pkg::PID_W-1:0]   i_first_particle,
    input  logic [bct_pkg::PID_W-1:0]   i_second_particle,
    input  logic                        i_rand_bit,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bct_pkg::CARD_W-1:0]  o_total_cardinality,
    output logic [bct_pkg::REC_W-1:0]   o_internal_recollisions,
    output logic [bct_pkg::REC_W-1:0]   o_external_recollisions
);
    import bct_pkg::*;

    localparam int N      = NUM_PARTICLES;
    localparam int WAIT   = 2 * N + 2;
    localparam int CW     = $clog2(WAIT + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RPT  = 1'b1;

    logic              r_state;
    logic [CW-1:0]     r_cnt;
    logic              r_out_valid;
    logic              in_acc, out_free, done, in_range;
    t_cmd              cmd;
    logic [N:0][N-1:0] up;
    t_link [N:0]       link;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign done       = (r_state == ST_RPT) && (r_cnt == CW'(WAIT)) && out_free;
    assign in_range   = (WIDE_W'(i_first_particle) < WIDE_W'(N))
                     && (WIDE_W'(i_second_particle) < WIDE_W'(N));

    always_comb begin
        cmd.upd      = in_acc && (i_req_type == REQ_COLLIDE) && in_range;
        cmd.clr_diag = done;
        cmd.p1       = i_first_particle;
        cmd.p2       = i_second_particle;
        // both-member rows flag the same way whichever count is bumped
        cmd.rb       = i_rand_bit;
    end

    assign up[N]   = '0;
    assign link[N] = '0;

    for (genvar g = 0; g < N; g++) begin : g_row
        bct_cell #(.N(N), .IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (cmd),
            .i_up   (up[g+1]),
            .i_link (link[g+1]),
            .o_up   (up[g]),
            .o_link (link[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_req_type == REQ_REPORT)) begin
                        r_state <= ST_RPT;
                        r_cnt   <= '0;
                    end
                end
                ST_RPT: begin
                    if (r_cnt != CW'(WAIT)) begin
                        r_cnt <= r_cnt + CW'(1);
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            o_total_cardinality     <= link[0].card;
            o_internal_recollisions <= link[0].rint;
            o_external_recollisions <= link[0].rext;
        end
    end

    assign o_out_valid = r_out_valid;

    `BCT_ASSERT_IMP(a_upd_idle, cmd.upd, r_state == ST_IDLE)
    `BCT_ASSERT_NXT(a_rpt_start, in_acc && (i_req_type == REQ_REPORT), r_state == ST_RPT)
    `BCT_ASSERT_NXT(a_done_out, done, r_out_valid && r_state == ST_IDLE)
endmodule

@@ rtl/core/bct_cell.sv @@
// One particle row: membership bitmap, recollision flags and chain stages.
module bct_cell #(
    parameter int N   = 64,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bct_pkg::t_cmd  i_cmd,
    input  logic [N-1:0]  i_up,
    input  bct_pkg::t_link i_link,
    output logic [N-1:0]  o_up,
    output bct_pkg::t_link o_link
);
    import bct_pkg::*;

    localparam int IW = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0]      r_row, n_row;
    logic              r_nd_over, n_nd_over;
    logic              r_dg_over, n_dg_over;
    logic [N-1:0]      r_sfx;
    t_link             r_link, n_link;
    logic [WIDE_W-1:0] w1, w2;
    logic [IW-1:0]     ix1, ix2;
    logic              is_p1, is_p2, a, b;

    assign w1    = {{(WIDE_W-PID_W){1'b0}}, i_cmd.p1};
    assign w2    = {{(WIDE_W-PID_W){1'b0}}, i_cmd.p2};
    assign ix1   = w1[IW-1:0];
    assign ix2   = w2[IW-1:0];
    assign is_p1 = (w1 == WIDE_W'(IDX));
    assign is_p2 = (w2 == WIDE_W'(IDX));
    assign a     = r_row[ix1];
    assign b     = r_row[ix2];

    always_comb begin
        n_row     = r_row;
        n_nd_over = r_nd_over;
        n_dg_over = r_dg_over & ~i_cmd.clr_diag;
        if (i_cmd.upd) begin
            if (is_p1) begin
                if (b) begin
                    // self collision bumps the diagonal
                    if (is_p2) n_dg_over = 1'b1;
                    else       n_nd_over = 1'b1;
                end else begin
                    n_row[ix2] = 1'b1;
                end
            end else if (is_p2) begin
                if (a) n_nd_over = 1'b1;
                else   n_row[ix1] = 1'b1;
            end else if (a && !b) begin
                n_row[ix2] = 1'b1;
            end else if (b && !a) begin
                n_row[ix1] = 1'b1;
            end else if (a && b) begin
                n_nd_over = 1'b1;
            end
        end
    end

    // r_sfx settles to the union of all rows below in the chain
    always_comb begin
        n_link.card = i_link.card + CARD_W'($countones(r_row));
        n_link.rint = i_link.rint + REC_W'(r_nd_over | r_dg_over);
        n_link.rext = i_link.rext + REC_W'(|(r_row & r_sfx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= N'(1) << IDX;
            r_nd_over <= 1'b0;
            r_dg_over <= 1'b0;
        end else begin
            r_row     <= n_row;
            r_nd_over <= n_nd_over;
            r_dg_over <= n_dg_over;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sfx  <= i_up;
        r_link <= n_link;
    end

    assign o_up   = r_row | r_sfx;
    assign o_link = r_link;
endmodule

@@ verif/backward_cluster_tracker_checker.sv @@
// Cluster tracker checker: watches both channels, predicts reports and compares them.
`timescale 1ns / 100ps
module backward_cluster_tracker_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_req_type,
    input  logic [bct_pkg::PID_W-1:0]   i_first_particle,
    input  logic [bct_pkg::PID_W-1:0]   i_second_particle,
    input  logic                        i_rand_bit,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [bct_pkg::CARD_W-1:0]  i_total_cardinality,
    input  logic [bct_pkg::REC_W-1:0]   i_internal_recollisions,
    input  logic [bct_pkg::REC_W-1:0]   i_external_recollisions,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_reports
);
    import bct_pkg::*;

    localparam int NP = 64;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [CARD_W-1:0] card;
        logic [REC_W-1:0]  rint;
        logic [REC_W-1:0]  rext;
    } t_stats;

    logic [NP-1:0] cluster_rows [NP];
    logic [15:0]   member_cnt [NP][NP];
    t_stats        stats_due [$];

    task automatic clear_clusters();
        for (int r = 0; r < NP; r++) begin
            cluster_rows[r] = '0;
            for (int m = 0; m < NP; m++) member_cnt[r][m] = '0;
            cluster_rows[r][r] = 1'b1;
            member_cnt[r][r] = 16'd1;
        end
    endtask

    task automatic join_cluster(int r, int p);
        cluster_rows[r][p] = 1'b1;
        member_cnt[r][p] = 16'd1;
    endtask

    task automatic join_or_bump(int r, int p);
        if (!cluster_rows[r][p]) join_cluster(r, p);
        else if (member_cnt[r][p] < COUNT_MAX) member_cnt[r][p]++;
    endtask

    task automatic apply_collision(int p1, int p2, logic rb);
        logic a, b;
        for (int r = 0; r < NP; r++) begin
            if (r == p1) begin
                join_or_bump(r, p2);
            end else if (r == p2) begin
                join_or_bump(r, p1);
            end else begin
                a = cluster_rows[r][p1];
                b = cluster_rows[r][p2];
                if (a && !b) join_cluster(r, p2);
                else if (b && !a) join_cluster(r, p1);
                else if (a && b) join_or_bump(r, rb ? p2 : p1);
            end
        end
    endtask

    function automatic t_stats cluster_stats();
        t_stats s;
        int card, rint, rext;
        logic over, meets;
        card = 0; rint = 0; rext = 0;
        for (int r = 0; r < NP; r++) begin
            over = 1'b0;
            meets = 1'b0;
            card += $countones(cluster_rows[r]);
            for (int j = 0; j < NP; j++) if (member_cnt[r][j] > 16'd1) over = 1'b1;
            for (int j = r + 1; j < NP; j++)
                if ((cluster_rows[r] & cluster_rows[j]) != '0) meets = 1'b1;
            rint += int'(over);
            rext += int'(meets);
        end
        s.card = card[CARD_W-1:0];
        s.rint = rint[REC_W-1:0];
        s.rext = rext[REC_W-1:0];
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_stats want;
        if (!i_rst_n) begin
            clear_clusters();
            stats_due.delete();
            o_errors <= 0;
            o_reports <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_req_type == REQ_COLLIDE) begin
                    apply_collision(int'(i_first_particle), int'(i_second_particle),
                                    i_rand_bit);
                end else begin
                    stats_due.push_back(cluster_stats());
                    for (int r = 0; r < NP; r++) join_cluster(r, r);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_reports <= o_reports + 1;
                if (stats_due.size() == 0) begin
                    $display("%0t: unexpected report transaction card=%0d int=%0d ext=%0d",
                             $time, i_total_cardinality, i_internal_recollisions,
                             i_external_recollisions);
                    o_errors <= o_errors + 1;
                end else begin
                    want = stats_due.pop_front();
                    if (want.card !== i_total_cardinality ||
                        want.rint !== i_internal_recollisions ||
                        want.rext !== i_external_recollisions) begin
                        $display("%0t: report mismatch expected card=%0d int=%0d ext=%0d",
                                 $time, want.card, want.rint, want.rext);
                        $display("%0t:                 actual   card=%0d int=%0d ext=%0d",
                                 $time, i_total_cardinality, i_internal_recollisions,
                                 i_external_recollisions);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= stats_due.size();
    end
endmodule

@@ verif/backward_cluster_tracker_tb.sv @@
// Testbench top for the backward cluster tracker: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module backward_cluster_tracker_tb;
    import bct_pkg::*;

    localparam int   HANG_LIMIT  = 3000;
    localparam int   DRAIN_WAIT  = 200;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              req_type = REQ_COLLIDE;
    logic [PID_W-1:0]  first_p = '0;
    logic [PID_W-1:0]  second_p = '0;
    logic              rand_bit = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CARD_W-1:0] total_card;
    logic [REC_W-1:0]  int_rec;
    logic [REC_W-1:0]  ext_rec;
    int                errors, pending, reports;
    int                hang_cnt = 0;
    int                collisions = 0;
    bit                quiet = 1'b0;

    always #4 i_clk = ~i_clk;

    backward_cluster_tracker DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(req_type), .i_first_particle(first_p),
        .i_second_particle(second_p), .i_rand_bit(rand_bit),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_total_cardinality(total_card), .o_internal_recollisions(int_rec),
        .o_external_recollisions(ext_rec)
    );

    backward_cluster_tracker_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_req_type(req_type), .i_first_particle(first_p),
        .i_second_particle(second_p), .i_rand_bit(rand_bit),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_total_cardinality(total_card), .i_internal_recollisions(int_rec),
        .i_external_recollisions(ext_rec),
        .o_errors(errors), .o_pending(pending), .o_reports(reports)
    );

    always @(posedge i_clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 16);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) hang_cnt <= 0;
        else hang_cnt <= hang_cnt + 1;
        if (hang_cnt >= HANG_LIMIT) begin
            $display("backward_cluster_tracker_tb failed");
            $finish;
        end
    end

    // Valid is held until the transaction is taken; idle cycles come before it.
    task automatic send_req(logic rt, int p1, int p2, logic rb);
        while (!quiet && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        first_p  <= p1[PID_W-1:0];
        second_p <= p2[PID_W-1:0];
        rand_bit <= rb;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (rt == REQ_COLLIDE) collisions++;
    endtask

    task automatic drain_and_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Pair from a small neighborhood so clusters overlap; sometimes the full range.
    task automatic random_collision();
        int p1, p2;
        if ($urandom_range(3) == 0) begin
            p1 = $urandom_range(63);
            p2 = $urandom_range(63);
        end else begin
            p1 = $urandom_range(15);
            p2 = (p1 + $urandom_range(4)) % 16 + 16 * $urandom_range(3);
        end
        send_req(REQ_COLLIDE, p1, p2, 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: report on a fresh state, extremes, self collision, tie breaks.
        send_req(REQ_REPORT, 63, 0, 1'b1);
        send_req(REQ_COLLIDE, 0, 63, 1'b0);
        send_req(REQ_COLLIDE, 63, 0, 1'b1);
        send_req(REQ_COLLIDE, 5, 5, 1'b0);
        send_req(REQ_COLLIDE, 5, 9, 1'b1);
        send_req(REQ_COLLIDE, 9, 12, 1'b0);
        send_req(REQ_COLLIDE, 5, 12, 1'b0);
        send_req(REQ_COLLIDE, 5, 12, 1'b1);
        send_req(REQ_COLLIDE, 42, 21, 1'b1);
        send_req(REQ_COLLIDE, 21, 42, 1'b0);
        send_req(REQ_REPORT, 0, 0, 1'b0);
        send_req(REQ_REPORT, 21, 42, 1'b1);
        send_req(REQ_COLLIDE, 12, 12, 1'b1);
        send_req(REQ_REPORT, 63, 63, 1'b0);
        drain_and_idle();

        // Bump one diagonal count repeatedly with back to back self collisions.
        quiet = 1'b1;
        repeat (24) send_req(REQ_COLLIDE, 3, 3, 1'b0);
        send_req(REQ_REPORT, 0, 63, 1'b0);
        drain_and_idle();

        // Random part; the middle stretch runs without idling.
        for (int n = 0; n < 700; n++) begin
            quiet = (n >= 300 && n < 420);
            if ($urandom_range(14) == 0) send_req(REQ_REPORT, $urandom_range(63),
                                                  $urandom_range(63),
                                                  1'($urandom_range(1)));
            else random_collision();
            if (n == 500) drain_and_idle();
        end
        quiet = 1'b0;
        send_req(REQ_REPORT, 0, 0, 1'b0);
        drain_and_idle();

        $display("Ran %0d collisions and checked %0d report transactions,", collisions,
                 reports);
        $display("including self collisions, repeated diagonal bumps and both tie breaks.");
        if (errors == 0) $display("backward_cluster_tracker_tb passed");
        else $display("backward_cluster_tracker_tb failed");
        $finish;
    end
endmodule
